/* src/zsd_pkg.sv */
package zsd_pkg;

  // parse phases, one-hot
  typedef enum logic [12:0] {
    PH_CMF   = 13'b0_0000_0000_0001,
    PH_FLG   = 13'b0_0000_0000_0010,
    PH_BHDR  = 13'b0_0000_0000_0100,
    PH_LEN0  = 13'b0_0000_0000_1000,
    PH_LEN1  = 13'b0_0000_0001_0000,
    PH_NLEN0 = 13'b0_0000_0010_0000,
    PH_NLEN1 = 13'b0_0000_0100_0000,
    PH_DATA  = 13'b0_0000_1000_0000,
    PH_ADL0  = 13'b0_0001_0000_0000,
    PH_ADL1  = 13'b0_0010_0000_0000,
    PH_ADL2  = 13'b0_0100_0000_0000,
    PH_ADL3  = 13'b0_1000_0000_0000,
    PH_DONE  = 13'b1_0000_0000_0000
  } phase_t;

  // verdict codes
  localparam logic [3:0] ST_NONE  = 4'd0;
  localparam logic [3:0] ST_OK    = 4'd1;
  localparam logic [3:0] ST_TRUNC = 4'd2;
  localparam logic [3:0] ST_FCHK  = 4'd3;
  localparam logic [3:0] ST_METH  = 4'd4;
  localparam logic [3:0] ST_DICT  = 4'd5;
  localparam logic [3:0] ST_BTYPE = 4'd6;
  localparam logic [3:0] ST_LEN   = 4'd7;
  localparam logic [3:0] ST_ADLER = 4'd8;

  localparam logic [16:0] ADLER_MOD = 17'd65521;
  localparam logic [3:0]  CM_DEFLATE = 4'd8;

  typedef struct packed {
    logic feed;
    logic clear;
  } adler_ctrl_t;

endpackage

/* src/zsd_in_if.sv */
interface zsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink (input valid, input in_byte, input last_byte, output ready);
endinterface

/* src/zsd_out_if.sv */
interface zsd_out_if;
  logic       valid;
  logic       ready;
  logic       has_data;
  logic [7:0] out_byte;
  logic [3:0] status;

  modport source (output valid, output has_data, output out_byte, output status,
                  input ready);
  modport sink (input valid, input has_data, input out_byte, input status,
                output ready);
endinterface

/* src/zsd_adler.sv */
module zsd_adler
  import zsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  adler_ctrl_t ctrl,
  input  logic [7:0]  data,
  output logic [15:0] sum_a,
  output logic [15:0] sum_b
);

  logic [16:0] a_raw;
  logic [15:0] a_mod;
  logic [16:0] b_raw;
  logic [15:0] b_mod;

  always_comb begin
    a_raw = {1'b0, sum_a} + {9'd0, data};
    a_mod = (a_raw >= ADLER_MOD) ? 16'(a_raw - ADLER_MOD) : a_raw[15:0];
    b_raw = {1'b0, sum_b} + {1'b0, a_mod};
    b_mod = (b_raw >= ADLER_MOD) ? 16'(b_raw - ADLER_MOD) : b_raw[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      sum_a <= 16'd1;
      sum_b <= 16'd0;
    end else if (ctrl.feed) begin
      sum_a <= a_mod;
      sum_b <= b_mod;
    end
  end

endmodule

/* src/zlib_stored_deframer_unit.sv */
// zlib stream checker for streams made only of stored blocks.
// in_ch carries one stream byte per transaction with last_byte marking the
// end of the stream; out_ch carries results: a payload byte (has_data) and/or
// a verdict in status (1 ok, 2 truncated, 3..8 the failing check).
// A byte yields at most one result, registered when the byte is accepted.
// Payload is passed on as it arrives; a consumer drops it on an error verdict.
// Throughput is one byte per cycle while out_ch is not stalled: the header,
// length and Adler-32 check logic is combinational up to the result register.
// After a verdict, bytes give no result until one with last_byte, which
// returns the block to its start state once that byte is handled.
// Reset (rst, synchronous) sets the start state and empties the result
// register. When the receiver holds out_ch.ready low, one result waits in the
// register and in_ch.ready stays low until that result is taken.
module zlib_stored_deframer_unit
  import zsd_pkg::*;
(
  input logic     clk,
  input logic     rst,
  zsd_in_if.sink  in_ch,
  zsd_out_if.source out_ch
);

  phase_t      phase, phase_next;
  logic [7:0]  first_header_byte, first_header_byte_next;
  logic        final_block_flag, final_block_flag_next;
  logic [15:0] block_length, block_length_next;
  logic [7:0]  complement_low_byte, complement_low_byte_next;
  logic [15:0] bytes_remaining, bytes_remaining_next;
  logic [23:0] expected_checksum_high, expected_checksum_high_next;

  logic        out_valid;
  logic        res_has;
  logic [7:0]  res_byte;
  logic [3:0]  res_status;
  logic        fire;
  logic        last;
  logic [7:0]  b;

  logic [15:0] sum_a, sum_b;
  adler_ctrl_t adler_ctrl;

  // fcheck: (cmf*256 + flg) mod 31, with 256 = 8 and 32 = 1 mod 31
  logic [11:0] fc_x;
  logic [6:0]  fc_y;
  logic [5:0]  fc_z;
  logic        fc_bad;
  logic [15:0] rem_dec;

  assign b      = in_ch.in_byte;
  assign last   = in_ch.last_byte;
  assign fire   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign out_ch.valid = out_valid;

  always_comb begin
    fc_x   = {1'b0, first_header_byte, 3'b000} + {4'd0, b};
    fc_y   = {2'b00, fc_x[4:0]} + {2'b00, fc_x[9:5]} + {5'd0, fc_x[11:10]};
    fc_z   = {1'b0, fc_y[4:0]} + {4'd0, fc_y[6:5]};
    fc_bad = !((fc_z == 6'd0) || (fc_z == 6'd31));
    rem_dec = bytes_remaining - 16'd1;
  end

  always_comb begin
    phase_next                  = phase;
    first_header_byte_next      = first_header_byte;
    final_block_flag_next       = final_block_flag;
    block_length_next           = block_length;
    complement_low_byte_next    = complement_low_byte;
    bytes_remaining_next        = bytes_remaining;
    expected_checksum_high_next = expected_checksum_high;
    res_has    = 1'b0;
    res_byte   = 8'd0;
    res_status = ST_NONE;
    adler_ctrl.feed  = 1'b0;
    adler_ctrl.clear = fire && last;

    case (phase)
      PH_CMF: begin
        first_header_byte_next = b;
        phase_next = PH_FLG;
        if (last) res_status = ST_TRUNC;
      end
      PH_FLG: begin
        if (last) res_status = ST_TRUNC;
        else if (fc_bad) res_status = ST_FCHK;
        else if (first_header_byte[3:0] != CM_DEFLATE) res_status = ST_METH;
        else if (b[5]) res_status = ST_DICT;
        else phase_next = PH_BHDR;
      end
      PH_BHDR: begin
        final_block_flag_next = b[0];
        if (b[2:1] != 2'b00) res_status = ST_BTYPE;
        else begin
          phase_next = PH_LEN0;
          if (last) res_status = ST_TRUNC;
        end
      end
      PH_LEN0: begin
        block_length_next = {8'd0, b};
        phase_next = PH_LEN1;
        if (last) res_status = ST_TRUNC;
      end
      PH_LEN1: begin
        block_length_next = {b, block_length[7:0]};
        phase_next = PH_NLEN0;
        if (last) res_status = ST_TRUNC;
      end
      PH_NLEN0: begin
        complement_low_byte_next = b;
        phase_next = PH_NLEN1;
        if (last) res_status = ST_TRUNC;
      end
      PH_NLEN1: begin
        if (~block_length != {b, complement_low_byte}) res_status = ST_LEN;
        else begin
          bytes_remaining_next = block_length;
          if (block_length == 16'd0) phase_next = final_block_flag ? PH_ADL0 : PH_BHDR;
          else phase_next = PH_DATA;
          if (last) res_status = ST_TRUNC;
        end
      end
      PH_DATA: begin
        res_has  = 1'b1;
        res_byte = b;
        adler_ctrl.feed = fire;
        bytes_remaining_next = rem_dec;
        if (rem_dec == 16'd0) phase_next = final_block_flag ? PH_ADL0 : PH_BHDR;
        if (last) res_status = ST_TRUNC;
      end
      PH_ADL0, PH_ADL1, PH_ADL2: begin
        expected_checksum_high_next = {expected_checksum_high[15:0], b};
        case (phase)
          PH_ADL0: phase_next = PH_ADL1;
          PH_ADL1: phase_next = PH_ADL2;
          default: phase_next = PH_ADL3;
        endcase
        if (last) res_status = ST_TRUNC;
      end
      PH_ADL3: begin
        res_status = ({expected_checksum_high, b} == {sum_b, sum_a}) ? ST_OK : ST_ADLER;
      end
      default: begin
      end
    endcase

    if (res_status != ST_NONE) phase_next = PH_DONE;
  end

  zsd_adler u_adler (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (adler_ctrl),
    .data  (b),
    .sum_a (sum_a),
    .sum_b (sum_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase                  <= PH_CMF;
      first_header_byte      <= 8'd0;
      final_block_flag       <= 1'b0;
      block_length           <= 16'd0;
      complement_low_byte    <= 8'd0;
      bytes_remaining        <= 16'd0;
      expected_checksum_high <= 24'd0;
    end else if (fire) begin
      if (last) begin
        // end of stream rearms the parser
        phase                  <= PH_CMF;
        first_header_byte      <= 8'd0;
        final_block_flag       <= 1'b0;
        block_length           <= 16'd0;
        complement_low_byte    <= 8'd0;
        bytes_remaining        <= 16'd0;
        expected_checksum_high <= 24'd0;
      end else begin
        phase                  <= phase_next;
        first_header_byte      <= first_header_byte_next;
        final_block_flag       <= final_block_flag_next;
        block_length           <= block_length_next;
        complement_low_byte    <= complement_low_byte_next;
        bytes_remaining        <= bytes_remaining_next;
        expected_checksum_high <= expected_checksum_high_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && (res_has || res_status != ST_NONE)) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && (res_has || res_status != ST_NONE)) begin
      out_ch.has_data <= res_has;
      out_ch.out_byte <= res_byte;
      out_ch.status   <= res_status;
    end
  end

endmodule

/* bench/tb_zlib_stored_deframer_unit.sv */
`timescale 1ns / 1ps

module tb_zlib_stored_deframer_unit;
  import zsd_pkg::*;

  typedef struct packed {
    logic       has;
    logic [7:0] ob;
    logic [3:0] st;
  } result_t;

  // how a directed row is checked
  typedef enum logic [1:0] {
    BY_MODEL,
    LIT_RESULT,
    LIT_QUIET
  } row_chk_t;

  typedef struct packed {
    logic [7:0] b;
    logic       is_last;
    row_chk_t   how;
    logic       has;
    logic [7:0] ob;
    logic [3:0] st;
  } stim_row_t;

  localparam int N_DIRECTED = 32;

  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    // good stream: one final stored block holding 0xff
    '{8'h78, 1'b0, BY_MODEL,   1'b0, 8'h00, ST_NONE},
    '{8'h01, 1'b0, BY_MODEL,   1'b0, 8'h00, ST_NONE},
    '{8'h01, 1'b0, BY_MODEL,   1'b0, 8'h00, ST_NONE},
    '{8'h01, 1'b0, BY_MODEL,   1'b0, 8'h00, ST_NONE},
    '{8'h00, 1'b0, BY_MODEL,   1'b0, 8'h00, ST_NONE},
    '{8'hFE, 1'b0, BY_MODEL,   1'b0, 8'h00, ST_NONE},
    '{8'hFF, 1'b0, BY_MODEL,   1'b0, 8'h00, ST_NONE},
    '{8'hFF, 1'b0, LIT_RESULT, 1'b1, 8'hFF, ST_NONE},
    '{8'h01, 1'b0, BY_MODEL,   1'b0, 8'h00, ST_NONE},
    '{8'h00, 1'b0, BY_MODEL,   1'b0, 8'h00, ST_NONE},
    '{8'h01, 1'b0, BY_MODEL,   1'b0, 8'h00, ST_NONE},
    '{8'h00, 1'b1, LIT_RESULT, 1'b0, 8'h00, ST_OK},
    // fcheck fails, then a byte after the verdict is ignored
    '{8'h78, 1'b0, BY_MODEL,   1'b0, 8'h00, ST_NONE},
    '{8'h00, 1'b0, LIT_RESULT, 1'b0, 8'h00, ST_FCHK},
    '{8'hFF, 1'b1, LIT_QUIET,  1'b0, 8'h00, ST_NONE},
    // method 7
    '{8'h77, 1'b0, BY_MODEL,   1'b0, 8'h00, ST_NONE},
    '{8'h09, 1'b0, LIT_RESULT, 1'b0, 8'h00, ST_METH},
    '{8'h00, 1'b1, LIT_QUIET,  1'b0, 8'h00, ST_NONE},
    // preset dictionary
    '{8'h78, 1'b0, BY_MODEL,   1'b0, 8'h00, ST_NONE},
    '{8'h20, 1'b0, LIT_RESULT, 1'b0, 8'h00, ST_DICT},
    '{8'h80, 1'b1, LIT_QUIET,  1'b0, 8'h00, ST_NONE},
    // reserved block type wins over end of stream
    '{8'h78, 1'b0, BY_MODEL,   1'b0, 8'h00, ST_NONE},
    '{8'h01, 1'b0, BY_MODEL,   1'b0, 8'h00, ST_NONE},
    '{8'h06, 1'b1, LIT_RESULT, 1'b0, 8'h00, ST_BTYPE},
    // len/nlen disagree, also wins over end of stream
    '{8'h78, 1'b0, BY_MODEL,   1'b0, 8'h00, ST_NONE},
    '{8'h01, 1'b0, BY_MODEL,   1'b0, 8'h00, ST_NONE},
    '{8'h00, 1'b0, BY_MODEL,   1'b0, 8'h00, ST_NONE},
    '{8'h00, 1'b0, BY_MODEL,   1'b0, 8'h00, ST_NONE},
    '{8'h00, 1'b0, BY_MODEL,   1'b0, 8'h00, ST_NONE},
    '{8'h00, 1'b0, BY_MODEL,   1'b0, 8'h00, ST_NONE},
    '{8'h00, 1'b1, LIT_RESULT, 1'b0, 8'h00, ST_LEN},
    // stream ends on the first header byte
    '{8'h9C, 1'b1, LIT_RESULT, 1'b0, 8'h00, ST_TRUNC}
  };

  logic clk = 1'b0;
  logic rst;

  zsd_in_if  in_ch ();
  zsd_out_if out_ch ();

  zlib_stored_deframer_unit dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // parser shadow state
  phase_t      ph;
  logic [7:0]  cmf_q;
  logic        final_q;
  logic [15:0] blk_len;
  logic [7:0]  nlen_lo;
  logic [15:0] remain;
  logic [15:0] adl_a;
  logic [15:0] adl_b;
  logic [23:0] chk_hi;

  result_t     pending_results[$];
  logic [8:0]  stream_q[$];
  int          fail_count = 0;
  int          live_items = 0;
  int          tx_idle_pct = 28;
  int          rx_idle_pct = 82;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;

  function automatic void restart_parse();
    ph      = PH_CMF;
    cmf_q   = 8'h00;
    final_q = 1'b0;
    blk_len = 16'h0000;
    nlen_lo = 8'h00;
    remain  = 16'h0000;
    adl_a   = 16'd1;
    adl_b   = 16'd0;
    chk_hi  = 24'h000000;
  endfunction

  function automatic void queue_expect(input result_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic void add_stream_byte(input logic [8:0] v);
    stream_q.insert(stream_q.size(), v);
  endfunction

  function automatic void adler_step(inout logic [15:0] sa, inout logic [15:0] sb,
                                     input logic [7:0] d);
    logic [16:0] t;
    t = {1'b0, sa} + {9'd0, d};
    if (t >= ADLER_MOD) t = t - ADLER_MOD;
    sa = t[15:0];
    t = {1'b0, sb} + {1'b0, sa};
    if (t >= ADLER_MOD) t = t - ADLER_MOD;
    sb = t[15:0];
  endfunction

  // returns 1 when the byte produces a result
  function automatic bit deframe_byte(input logic [7:0] b, input logic is_last,
                                      output result_t r);
    logic [15:0] nlen;
    r = '0;
    r.st = ST_NONE;
    case (ph)
      PH_CMF: begin
        cmf_q = b;
        ph = PH_FLG;
        if (is_last) r.st = ST_TRUNC;
      end
      PH_FLG: begin
        if (is_last) r.st = ST_TRUNC;
        else if (({cmf_q, b} % 31) != 0) r.st = ST_FCHK;
        else if (cmf_q[3:0] != CM_DEFLATE) r.st = ST_METH;
        else if (b[5]) r.st = ST_DICT;
        else ph = PH_BHDR;
      end
      PH_BHDR: begin
        final_q = b[0];
        if (b[2:1] != 2'b00) begin
          r.st = ST_BTYPE;
        end else begin
          ph = PH_LEN0;
          if (is_last) r.st = ST_TRUNC;
        end
      end
      PH_LEN0: begin
        blk_len = {8'h00, b};
        ph = PH_LEN1;
        if (is_last) r.st = ST_TRUNC;
      end
      PH_LEN1: begin
        blk_len[15:8] = b;
        ph = PH_NLEN0;
        if (is_last) r.st = ST_TRUNC;
      end
      PH_NLEN0: begin
        nlen_lo = b;
        ph = PH_NLEN1;
        if (is_last) r.st = ST_TRUNC;
      end
      PH_NLEN1: begin
        nlen = {b, nlen_lo};
        if (~blk_len != nlen) begin
          r.st = ST_LEN;
        end else begin
          remain = blk_len;
          if (remain == 16'd0) ph = final_q ? PH_ADL0 : PH_BHDR;
          else ph = PH_DATA;
          if (is_last) r.st = ST_TRUNC;
        end
      end
      PH_DATA: begin
        r.has = 1'b1;
        r.ob = b;
        adler_step(adl_a, adl_b, b);
        remain = remain - 16'd1;
        if (remain == 16'd0) ph = final_q ? PH_ADL0 : PH_BHDR;
        if (is_last) r.st = ST_TRUNC;
      end
      PH_ADL0, PH_ADL1, PH_ADL2: begin
        chk_hi = {chk_hi[15:0], b};
        ph = phase_t'(ph << 1);  // one-hot, next checksum byte
        if (is_last) r.st = ST_TRUNC;
      end
      PH_ADL3: begin
        r.st = ({chk_hi, b} == {adl_b, adl_a}) ? ST_OK : ST_ADLER;
      end
      default: ;
    endcase
    if (r.st != ST_NONE) ph = PH_DONE;
    if (is_last) restart_parse();
    return r.has || (r.st != ST_NONE);
  endfunction

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $time, msg);
  endfunction

  task automatic put_byte(input logic [7:0] b, input logic is_last, input row_chk_t how,
                          input result_t lit);
    result_t r;
    bit      some;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.in_byte   <= b;
    in_ch.last_byte <= is_last;
    do @(posedge clk); while (!in_ch.ready);
    if (ph != PH_DONE) live_items++;
    some = deframe_byte(b, is_last, r);
    if (how == LIT_RESULT) queue_expect(lit);
    else if (how == BY_MODEL && some) queue_expect(r);
  endtask

  // mostly well-formed streams; some corrupted, cut short or pure noise
  task automatic build_stream();
    logic [7:0]  cmf;
    logic [7:0]  flg;
    logic [7:0]  d;
    logic [15:0] len;
    logic [15:0] sa;
    logic [15:0] sb;
    int          kind;
    int          pick;
    int          nblk;
    int          cut;
    int          pos;
    stream_q.delete();
    kind = $urandom_range(0, 99);
    if (kind >= 90) begin
      repeat ($urandom_range(1, 12)) add_stream_byte({1'b0, 8'($urandom)});
    end else begin
      sa = 16'd1;
      sb = 16'd0;
      cmf = {4'($urandom_range(0, 15)), CM_DEFLATE};
      flg = {2'($urandom_range(0, 3)), 6'd0};
      flg[4:0] = 5'((31 - ({cmf, flg} % 31)) % 31);
      add_stream_byte({1'b0, cmf});
      add_stream_byte({1'b0, flg});
      nblk = $urandom_range(1, 3);
      for (int i = 0; i < nblk; i++) begin
        add_stream_byte({1'b0, 5'($urandom), 2'b00, 1'(i == nblk - 1)});
        pick = $urandom_range(0, 99);
        if (pick < 10) len = 16'd0;
        else if (pick < 97) len = 16'($urandom_range(1, 12));
        else len = 16'($urandom_range(100, 300));
        add_stream_byte({1'b0, len[7:0]});
        add_stream_byte({1'b0, len[15:8]});
        add_stream_byte({1'b0, ~len[7:0]});
        add_stream_byte({1'b0, ~len[15:8]});
        repeat (len) begin
          d = 8'($urandom);
          adler_step(sa, sb, d);
          add_stream_byte({1'b0, d});
        end
      end
      add_stream_byte({1'b0, sb[15:8]});
      add_stream_byte({1'b0, sb[7:0]});
      add_stream_byte({1'b0, sa[15:8]});
      add_stream_byte({1'b0, sa[7:0]});
      // trailing bytes after the verdict
      if ($urandom_range(0, 99) < 15)
        repeat ($urandom_range(1, 3)) add_stream_byte({1'b0, 8'($urandom)});
      if (kind >= 80) begin
        cut = $urandom_range(0, stream_q.size() - 1);
        while (stream_q.size() > cut + 1) void'(stream_q.pop_back());
      end else if (kind >= 70) begin
        pos = $urandom_range(0, stream_q.size() - 1);
        stream_q[pos][7:0] = stream_q[pos][7:0] ^ 8'($urandom_range(1, 255));
      end
    end
    stream_q[stream_q.size() - 1][8] = 1'b1;
  endtask

  initial begin
    rst             <= 1'b1;
    in_ch.valid     <= 1'b0;
    in_ch.in_byte   <= 8'h00;
    in_ch.last_byte <= 1'b0;
    restart_parse();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < N_DIRECTED; i++)
      put_byte(DIRECTED[i].b, DIRECTED[i].is_last, DIRECTED[i].how,
               '{DIRECTED[i].has, DIRECTED[i].ob, DIRECTED[i].st});
    while (live_items < 1400) begin
      if (live_items < 467) begin
        tx_idle_pct = 28;
        rx_idle_pct = 82;
      end else if (live_items < 934) begin
        tx_idle_pct = 82;
        rx_idle_pct = 28;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req = 1'b1;
      end
      build_stream();
      foreach (stream_q[j]) put_byte(stream_q[j][7:0], stream_q[j][8], BY_MODEL, '0);
    end
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // receiver: random back-pressure plus one long hold-off
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    result_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          note_failure($sformatf("unexpected result: has_data=%0b out_byte=%02h status=%0d",
                                 out_ch.has_data, out_ch.out_byte, out_ch.status));
        end else begin
          want = pending_results.pop_front();
          if (out_ch.has_data !== want.has || out_ch.status !== want.st ||
              out_ch.out_byte !== want.ob)
            note_failure($sformatf(
              "mismatch: exp has_data=%0b out_byte=%02h status=%0d, got %0b %02h %0d",
              want.has, want.ob, want.st,
              out_ch.has_data, out_ch.out_byte, out_ch.status));
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

/* files.f */
src/zsd_pkg.sv
src/zsd_in_if.sv
src/zsd_out_if.sv
src/zsd_adler.sv
src/zlib_stored_deframer_unit.sv
bench/tb_zlib_stored_deframer_unit.sv
